// ----- rtl/serial_set_triangle_wave_generator_top_macros.svh -----
// assertion macros for the serial set triangle wave generator
// used by the top level only; empty bodies when SYNTHESIS is defined
`ifndef SERIAL_SET_TRIANGLE_WAVE_GENERATOR_TOP_MACROS_SVH
`define SERIAL_SET_TRIANGLE_WAVE_GENERATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SSWG_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sswg check failed");
// next-cycle implication
`define SSWG_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sswg check failed");
`else
`define SSWG_ASSERT_IMPL(name, clk, rst, ante, cons)
`define SSWG_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/sswg_pkg.sv -----
// shared types, constants and the digit conversion function
// no dependencies
package sswg_pkg;

   localparam int DIGIT_SLOTS = 3;
   localparam int CNT_W       = $clog2(DIGIT_SLOTS + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [9:0] DEC_BASE   = 10'd10;
   localparam logic [7:0] AMP_MAX    = 8'd255;

   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_DIGIT,
      CMD_FREQ,
      CMD_AMP,
      CMD_TICK
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [3:0] digit;
   } q_entry_type;

   typedef logic [3:0] digits_type [DIGIT_SLOTS];

   // decimal value of all slots, first slot most significant
   function automatic logic [9:0] buffer_value(input digits_type digits);
      logic [9:0] acc;
      acc = '0;
      for (int k = 0; k < DIGIT_SLOTS; k++) begin
         acc = 10'(acc * DEC_BASE) + 10'(digits[k]);
      end
      return acc;
   endfunction

endpackage

// ----- rtl/sswg_if.sv -----
// valid/ready channel interfaces for request and response words
// no dependencies
interface sswg_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] rx_byte;

   modport source (output valid, output mode, output rx_byte, input ready);
   modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface sswg_rsp_if;
   logic       valid;
   logic       ready;
   logic       sample_valid;
   logic [7:0] sample;
   logic       freq_latched;
   logic       amp_latched;
   logic [9:0] freq_value;
   logic [7:0] amp_value;

   modport source (output valid, output sample_valid, output sample, output freq_latched,
                   output amp_latched, output freq_value, output amp_value, input ready);
   modport sink   (input valid, input sample_valid, input sample, input freq_latched,
                   input amp_latched, input freq_value, input amp_value, output ready);
endinterface

// ----- rtl/sswg_front.sv -----
// front end: accepts request words and classifies them into commands
// depends on sswg_pkg and sswg_req_if
module sswg_front
   import sswg_pkg::*;
(
   sswg_req_if.sink    req_port,
   input  logic        q_full,
   output logic        q_push,
   output q_entry_type q_entry
);

   // accept whenever the queue has room
   assign req_port.ready = !q_full;
   assign q_push         = req_port.valid && !q_full;

   // decode the received byte
   always_comb begin
      q_entry.digit = 4'(req_port.rx_byte - CHAR_ZERO);
      if (req_port.mode == MODE_TICK) begin
         q_entry.cmd = CMD_TICK;
      end else if (req_port.rx_byte >= CHAR_ZERO && req_port.rx_byte <= CHAR_NINE) begin
         q_entry.cmd = CMD_DIGIT;
      end else if (req_port.rx_byte == CHAR_STAR) begin
         q_entry.cmd = CMD_FREQ;
      end else if (req_port.rx_byte == CHAR_HASH) begin
         q_entry.cmd = CMD_AMP;
      end else begin
         q_entry.cmd = CMD_NONE;
      end
   end

endmodule

// ----- rtl/sswg_queue.sv -----
// short command queue between front and back end
// depends on sswg_pkg
module sswg_queue
   import sswg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type push_entry,
   output logic        full,
   input  logic        pop,
   output logic        pop_valid,
   output q_entry_type pop_entry
);

   q_entry_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/sswg_back.sv -----
// back end: digit buffer, stored settings, wave stepping and output register
// depends on sswg_pkg and sswg_rsp_if
module sswg_back
   import sswg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  q_entry_type q_entry,
   output logic        q_pop,
   sswg_rsp_if.source  rsp_port
);

   digits_type           digits_ff, digits_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [9:0]           freq_ff, freq_in;
   logic                 freq_set_ff, freq_set_in;
   logic [7:0]           amp_ff, amp_in;
   logic                 amp_set_ff, amp_set_in;
   logic signed [9:0]    level_ff, level_in;
   logic                 rising_ff, rising_in;

   logic                 out_valid_ff, out_valid_in;
   logic                 smp_valid_ff, smp_valid_in;
   logic [7:0]           sample_ff, sample_in;
   logic                 flat_ff, flat_in;
   logic                 alat_ff, alat_in;

   logic [9:0]           buf_val;
   logic signed [9:0]    amp_s;
   logic signed [9:0]    lvl_tmp;

   // take a word when the output register is empty or being drained
   assign q_pop   = q_valid && (!out_valid_ff || rsp_port.ready);
   assign buf_val = buffer_value(digits_ff);
   assign amp_s   = signed'({2'b00, amp_ff});

   // command execution
   always_comb begin
      digits_in    = digits_ff;
      count_in     = count_ff;
      freq_in      = freq_ff;
      freq_set_in  = freq_set_ff;
      amp_in       = amp_ff;
      amp_set_in   = amp_set_ff;
      level_in     = level_ff;
      rising_in    = rising_ff;
      smp_valid_in = 1'b0;
      sample_in    = '0;
      flat_in      = 1'b0;
      alat_in      = 1'b0;
      lvl_tmp      = level_ff;
      out_valid_in = out_valid_ff && !rsp_port.ready;
      if (q_pop) begin
         out_valid_in = 1'b1;
         unique case (q_entry.cmd)
            CMD_DIGIT: begin
               // drop digits once every slot is filled
               for (int i = 0; i < DIGIT_SLOTS; i++) begin
                  if (count_ff == CNT_W'(i)) begin
                     digits_in[i] = q_entry.digit;
                  end
               end
               if (count_ff < CNT_W'(DIGIT_SLOTS)) begin
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_FREQ: begin
               freq_in     = buf_val;
               freq_set_in = 1'b1;
               count_in    = '0;
               flat_in     = 1'b1;
            end
            CMD_AMP: begin
               // saturate and reload the wave level
               amp_in     = (buf_val > 10'(AMP_MAX)) ? AMP_MAX : buf_val[7:0];
               amp_set_in = 1'b1;
               level_in   = signed'({2'b00, amp_in});
               count_in   = '0;
               alat_in    = 1'b1;
            end
            CMD_TICK: begin
               if (freq_set_ff && amp_set_ff) begin
                  if (!level_ff[9] && !rising_ff) begin
                     smp_valid_in = 1'b1;
                     sample_in    = level_ff[7:0];
                     lvl_tmp      = level_ff - 10'sd1;
                  end else if (level_ff <= amp_s) begin
                     lvl_tmp      = level_ff[9] ? 10'sd0 : level_ff;
                     rising_in    = 1'b1;
                     smp_valid_in = 1'b1;
                     sample_in    = lvl_tmp[7:0];
                     lvl_tmp      = lvl_tmp + 10'sd1;
                  end
                  // turn at the top
                  if (lvl_tmp > amp_s) begin
                     lvl_tmp   = amp_s;
                     rising_in = 1'b0;
                  end
                  level_in = lvl_tmp;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIGIT_SLOTS; i++) begin
            digits_ff[i] <= '0;
         end
         count_ff     <= '0;
         freq_ff      <= '0;
         freq_set_ff  <= 1'b0;
         amp_ff       <= '0;
         amp_set_ff   <= 1'b0;
         level_ff     <= '0;
         rising_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         digits_ff    <= digits_in;
         count_ff     <= count_in;
         freq_ff      <= freq_in;
         freq_set_ff  <= freq_set_in;
         amp_ff       <= amp_in;
         amp_set_ff   <= amp_set_in;
         level_ff     <= level_in;
         rising_ff    <= rising_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (q_pop) begin
         smp_valid_ff <= smp_valid_in;
         sample_ff    <= sample_in;
         flat_ff      <= flat_in;
         alat_ff      <= alat_in;
      end
   end

   assign rsp_port.valid        = out_valid_ff;
   assign rsp_port.sample_valid = smp_valid_ff;
   assign rsp_port.sample       = sample_ff;
   assign rsp_port.freq_latched = flat_ff;
   assign rsp_port.amp_latched  = alat_ff;
   assign rsp_port.freq_value   = freq_ff;
   assign rsp_port.amp_value    = amp_ff;

endmodule

// ----- rtl/serial_set_triangle_wave_generator_top.sv -----
// channel     | dir | payload
// req_port    | in  | mode, rx_byte
// rsp_port    | out | sample_valid, sample, freq_latched, amp_latched, freq_value, amp_value
//
// one word per cycle sustained while rsp_port.ready stays high; an accepted word reaches rsp_port
// through the queue write, then the back end step into the output register
// a two-word queue separates the decoder from the back end, so either side stalls alone
// synchronous active-high reset clears all settings, the wave level and the queue
// depends on sswg_pkg, sswg_if and the macros header
`include "serial_set_triangle_wave_generator_top_macros.svh"
module serial_set_triangle_wave_generator_top
   import sswg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   sswg_req_if.sink   req_port,
   sswg_rsp_if.source rsp_port
);

   logic        q_push, q_full, q_pop, q_valid;
   q_entry_type push_entry, pop_entry;
   logic        kind_clash, smp_shown, smp_idle;

   sswg_front u_front (
      .req_port (req_port),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (push_entry)
   );

   sswg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (pop_entry)
   );

   sswg_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_entry  (pop_entry),
      .q_pop    (q_pop),
      .rsp_port (rsp_port)
   );

   // checks
   assign kind_clash = (rsp_port.freq_latched && rsp_port.amp_latched)
                    || (rsp_port.sample_valid && (rsp_port.freq_latched || rsp_port.amp_latched));
   assign smp_shown  = rsp_port.valid && rsp_port.sample_valid;
   assign smp_idle   = rsp_port.valid && !rsp_port.sample_valid;

   `SSWG_ASSERT_IMPL(a_one_kind, clock, reset, rsp_port.valid, !kind_clash)
   `SSWG_ASSERT_IMPL(a_sample_range, clock, reset, smp_shown, rsp_port.sample <= rsp_port.amp_value)
   `SSWG_ASSERT_IMPL(a_idle_sample, clock, reset, smp_idle, rsp_port.sample == 8'd0)
   `SSWG_ASSERT_NEXT(a_pop_shows, clock, reset, q_pop, rsp_port.valid)

endmodule

// ----- tb/tb_top.sv -----
// testbench for the serial set triangle wave generator: directed and random words,
// each response checked against a predictor of the digit buffer, settings and wave level
// depends on sswg_pkg, sswg_if and serial_set_triangle_wave_generator_top
module tb_top
   import sswg_pkg::*;
();

   localparam int TOTAL_WORDS = 1700;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      logic       sample_valid;
      logic [7:0] sample;
      logic       freq_latched;
      logic       amp_latched;
      logic [9:0] freq_value;
      logic [7:0] amp_value;
   } wave_word_type;

   logic clock;
   logic reset;

   sswg_req_if req_port ();
   sswg_rsp_if rsp_port ();

   serial_set_triangle_wave_generator_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .rsp_port (rsp_port)
   );

   // predicted generator state, reset values
   logic [3:0] digit_slot [DIGIT_SLOTS] = '{default: '0};
   int         held_digits = 0;
   logic [9:0] freq_reg = '0;
   logic       freq_set = 1'b0;
   logic [7:0] amp_reg = '0;
   logic       amp_set = 1'b0;
   int         level = 0;
   logic       rising = 1'b0;

   wave_word_type wave_words_due [$];
   wave_word_type due_word;
   int         fail_count = 0;
   int         words_sent = 0;
   int         cycle_count = 0;
   logic       idling = 1'b1;
   int         hold_requests = 0;
   int         hold_served = 0;
   int         hold_left = 0;

   // clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // next response word for one accepted request word, advancing the predicted state
   function automatic wave_word_type next_wave_word(input logic m, input logic [7:0] b);
      wave_word_type w;
      int         value;
      int         amp_level;
      w = '0;
      value = 0;
      for (int k = 0; k < DIGIT_SLOTS; k++) begin
         value = value * 10 + int'(digit_slot[k]);
      end
      if (m == MODE_BYTE) begin
         if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            // a full buffer drops further digits
            if (held_digits < DIGIT_SLOTS) begin
               digit_slot[2'(held_digits)] = 4'(b - CHAR_ZERO);
               held_digits++;
            end
         end else if (b == CHAR_STAR) begin
            freq_reg = 10'(value);
            freq_set = 1'b1;
            held_digits = 0;
            w.freq_latched = 1'b1;
         end else if (b == CHAR_HASH) begin
            if (value > 255) value = 255;
            amp_reg = 8'(value);
            amp_set = 1'b1;
            level = value;
            held_digits = 0;
            w.amp_latched = 1'b1;
         end
      end else if (freq_set && amp_set) begin
         // falling towards zero, then rising back to the amplitude
         amp_level = int'(amp_reg);
         if (level >= 0 && !rising) begin
            w.sample_valid = 1'b1;
            w.sample = 8'(level);
            level--;
         end else if (level <= amp_level) begin
            if (level < 0) level = 0;
            rising = 1'b1;
            w.sample_valid = 1'b1;
            w.sample = 8'(level);
            level++;
         end
         if (level > amp_level) begin
            level = amp_level;
            rising = 1'b0;
         end
      end
      w.freq_value = freq_reg;
      w.amp_value = amp_reg;
      return w;
   endfunction

   function automatic void check_field(input string field, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endfunction

   // send one request word, with random idle cycles ahead of it
   task automatic send_word(input logic m, input logic [7:0] b);
      while (idling && $urandom_range(0, 99) < 10) begin
         req_port.valid <= 1'b0;
         @(posedge clock);
      end
      req_port.valid <= 1'b1;
      req_port.mode <= m;
      req_port.rx_byte <= b;
      do @(posedge clock); while (!req_port.ready);
      wave_words_due.push_back(next_wave_word(m, b));
      words_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_word(MODE_BYTE, 8'(s[i]));
      end
   endtask

   task automatic send_ticks(input int count);
      for (int i = 0; i < count; i++) begin
         send_word(MODE_TICK, 8'($urandom_range(0, 255)));
      end
   endtask

   // ticks give no sample until both frequency and amplitude are set
   task automatic test_unset_ticks;
      send_word(MODE_TICK, 8'hFF);
      send_text("250#");
      send_word(MODE_TICK, 8'h00);
   endtask

   // buffer full drops digits; a short entry keeps stale digits in later slots
   task automatic test_digit_buffer;
      send_text("1234*");
      send_text("7*");
   endtask

   // amplitude above 255 saturates
   task automatic test_amp_saturation;
      send_text("9#");
      send_ticks(2);
   endtask

   // small amplitude through both turning points
   task automatic test_wave_turns;
      send_text("002#");
      send_ticks(6);
   endtask

   // bytes next to the digit range and the extremes change nothing
   task automatic test_ignored_bytes;
      send_word(MODE_BYTE, 8'h00);
      send_word(MODE_BYTE, 8'hFF);
      send_word(MODE_BYTE, 8'h2F);
      send_word(MODE_BYTE, 8'h3A);
   endtask

   // receiver holds off for a long stretch while words keep coming
   task automatic test_output_backpressure;
      idling = 1'b0;
      hold_requests <= hold_requests + 1;
      send_text("010#");
      send_ticks(40);
      idling = 1'b1;
   endtask

   // mostly well-formed entries followed by ticks, some noise and broken entries
   task automatic test_random_traffic;
      int    value;
      int    ticks;
      string digits;
      while (words_sent < TOTAL_WORDS) begin
         // a long stretch with no idling on either side
         idling = !(words_sent >= 700 && words_sent < 1100);
         case ($urandom_range(0, 9))
            0: begin
               for (int i = $urandom_range(1, 3); i > 0; i--) begin
                  send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
               end
            end
            1: begin
               // digits left unterminated, then ticks
               send_text($sformatf("%0d", $urandom_range(0, 99)));
               send_ticks($urandom_range(1, 4));
            end
            default: begin
               case ($urandom_range(0, 9))
                  0:       value = 0;
                  1:       value = 999;
                  2, 3, 4, 5: value = $urandom_range(0, 9);
                  6, 7:    value = $urandom_range(10, 99);
                  default: value = $urandom_range(100, 999);
               endcase
               if ($urandom_range(0, 1)) digits = $sformatf("%03d", value);
               else digits = $sformatf("%0d", value);
               if ($urandom_range(0, 9) == 0) digits = {digits, "5"};
               send_text(digits);
               if ($urandom_range(0, 9) < 6) begin
                  send_text("#");
                  if (value <= 40 && $urandom_range(0, 3) == 0) ticks = 2 * value + 4;
                  else ticks = $urandom_range(0, 30);
               end else begin
                  send_text("*");
                  ticks = $urandom_range(0, 20);
               end
               send_ticks(ticks);
            end
         endcase
      end
   endtask

   // response ready: random stalls, plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_served + 1;
         hold_left <= HOLD_CYCLES;
         rsp_port.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_port.ready <= 1'b0;
      end else begin
         rsp_port.ready <= !(idling && $urandom_range(0, 99) < 10);
      end
   end

   // compare each accepted response word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_port.valid && rsp_port.ready) begin
         if (wave_words_due.size() == 0) begin
            $error("response word with none expected");
            fail_count++;
         end else begin
            due_word = wave_words_due.pop_front();
            check_field("sample_valid", 32'(due_word.sample_valid),
                        32'(rsp_port.sample_valid));
            check_field("sample", 32'(due_word.sample), 32'(rsp_port.sample));
            check_field("freq_latched", 32'(due_word.freq_latched),
                        32'(rsp_port.freq_latched));
            check_field("amp_latched", 32'(due_word.amp_latched),
                        32'(rsp_port.amp_latched));
            check_field("freq_value", 32'(due_word.freq_value), 32'(rsp_port.freq_value));
            check_field("amp_value", 32'(due_word.amp_value), 32'(rsp_port.amp_value));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // test sequence
   initial begin
      reset = 1'b1;
      req_port.valid = 1'b0;
      req_port.mode = MODE_BYTE;
      req_port.rx_byte = 8'h00;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_unset_ticks();
      test_digit_buffer();
      test_amp_saturation();
      test_wave_turns();
      test_ignored_bytes();
      test_output_backpressure();
      test_random_traffic();
      req_port.valid <= 1'b0;
      while (wave_words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/sswg_pkg.sv
rtl/sswg_if.sv
rtl/sswg_front.sv
rtl/sswg_queue.sv
rtl/sswg_back.sv
rtl/serial_set_triangle_wave_generator_top.sv
tb/tb_top.sv
